FILE: sv/cbd_pkg.sv
`default_nettype none

package cbd_pkg;

  // Largest number of hex digits accepted in one chunk size line.
  localparam int MAX_SIZE_DIGITS = 6;
  localparam int DIGIT_W = $clog2(MAX_SIZE_DIGITS + 1);

  localparam int SIZE_W = 24;

  // Decoder phases.
  localparam logic [2:0] PH_SIZE = 3'd0;
  localparam logic [2:0] PH_LF   = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_SKIP = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;
  localparam logic [2:0] PH_ERR  = 3'd5;

  // Characters that frame a size line.
  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  // Bytes skipped after each chunk's payload.
  localparam logic [1:0] SKIP_LEN = 2'd2;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       message_end;
    logic       format_error;
  } result_t;

  // Decode one ASCII hex digit; ok is low for any other character.
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.ok    = 1'b1;
    d.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      d.value = 4'(c[3:0] + 4'd9);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: sv/cbd_channels.sv
`default_nettype none

// Body byte channel.
interface cbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

// Decoded result channel.
interface cbd_result_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic       message_end;
  logic       format_error;

  modport source (output valid, output payload_valid, output payload_byte,
                  output message_end, output format_error, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input message_end, input format_error, output ready);
endinterface

`default_nettype wire

FILE: sv/chunked_body_decoder.sv
`default_nettype none

// Chunked message body decoder.
// Body bytes enter on the body channel (data_byte, first_byte) and one
// result word per byte leaves on the result channel (payload_valid,
// payload_byte, message_end, format_error). A word moves on a channel at
// a rising edge where valid and ready are both high.
// Each byte goes into an input register, the phase logic decodes it, and
// the result is written into an output register, from which the result
// word can be accepted once it is valid.
// One byte is taken per cycle as long as the receiver keeps ready high;
// the rate is set by the state update between the two registers.
// When the receiver stalls, the output register holds its word and the
// input register can still take one more byte; after that body.ready
// drops until the output drains.
// Reset empties both registers and puts the decoder in the size digits
// phase with all counters cleared. A byte with first_byte set restarts
// the decoder in the same way before it is handled.
module chunked_body_decoder (
  input  wire logic    clk,
  input  wire logic    rst,
  cbd_byte_if.sink     body,
  cbd_result_if.source result
);
  import cbd_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_first;
  logic       advance;
  logic       step;
  result_t    res;

  assign step       = s1_valid && advance;
  assign body.ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (body.ready) begin
      s1_valid <= body.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (body.ready && body.valid) begin
      s1_data  <= body.data_byte;
      s1_first <= body.first_byte;
    end
  end

  cbd_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (s1_data),
    .first_byte (s1_first),
    .res        (res)
  );

  cbd_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (s1_valid),
    .res     (res),
    .advance (advance),
    .result  (result)
  );

  // A message cannot both end and fail.
  a_end_xor_error: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.message_end && result.format_error))
    else $error("message_end and format_error both set");

  // Payload bytes only come from an open, error-free message.
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.payload_valid) |-> (!result.message_end && !result.format_error))
    else $error("payload byte flagged as end or error");

  // Non-payload words carry a zero byte.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.payload_valid) |-> (result.payload_byte == 8'd0))
    else $error("non-payload word carries a byte");

  // A held byte in the input register is never dropped.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("input register lost a byte");

endmodule

`default_nettype wire

FILE: sv/cbd_fsm.sv
`default_nettype none

module cbd_fsm (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      data_byte,
  input  wire logic            first_byte,
  output cbd_pkg::result_t     res
);
  import cbd_pkg::*;

  logic [2:0]         phase;
  logic [SIZE_W-1:0]  size_accumulator;
  logic [DIGIT_W-1:0] digit_count;
  logic [SIZE_W-1:0]  bytes_remaining;
  logic [1:0]         skip_count;

  logic [2:0]         phase_next;
  logic [SIZE_W-1:0]  size_accumulator_next;
  logic [DIGIT_W-1:0] digit_count_next;
  logic [SIZE_W-1:0]  bytes_remaining_next;
  logic [1:0]         skip_count_next;

  logic [2:0]         cur_phase;
  logic [SIZE_W-1:0]  cur_size;
  logic [DIGIT_W-1:0] cur_digits;
  logic [SIZE_W-1:0]  cur_remaining;
  logic [1:0]         cur_skip;
  logic [SIZE_W-1:0]  remaining_dec;
  logic [1:0]         skip_dec;
  hex_digit_t         hex;
  logic               valid;

  // A first byte starts from the reset state.
  always_comb begin
    if (first_byte) begin
      cur_phase     = PH_SIZE;
      cur_size      = '0;
      cur_digits    = '0;
      cur_remaining = '0;
      cur_skip      = '0;
    end else begin
      cur_phase     = phase;
      cur_size      = size_accumulator;
      cur_digits    = digit_count;
      cur_remaining = bytes_remaining;
      cur_skip      = skip_count;
    end
  end

  assign hex           = hex_decode(data_byte);
  assign remaining_dec = cur_remaining - SIZE_W'(1);
  assign skip_dec      = cur_skip - 2'd1;

  // Phase transitions for one byte.
  always_comb begin
    phase_next            = cur_phase;
    size_accumulator_next = cur_size;
    digit_count_next      = cur_digits;
    bytes_remaining_next  = cur_remaining;
    skip_count_next       = cur_skip;
    valid                 = 1'b0;
    case (cur_phase)
      PH_SIZE: begin
        if (data_byte == CHAR_CR) begin
          phase_next = PH_LF;
        end else if (!hex.ok || cur_digits >= DIGIT_W'(MAX_SIZE_DIGITS)) begin
          phase_next = PH_ERR;
        end else begin
          size_accumulator_next = {cur_size[SIZE_W-5:0], hex.value};
          digit_count_next      = DIGIT_W'(cur_digits + 1'b1);
        end
      end
      PH_LF: begin
        if (data_byte != CHAR_LF) begin
          phase_next = PH_ERR;
        end else if (cur_size == '0) begin
          phase_next = PH_DONE;
        end else begin
          bytes_remaining_next = cur_size;
          phase_next           = PH_DATA;
        end
      end
      PH_DATA: begin
        valid                = 1'b1;
        bytes_remaining_next = remaining_dec;
        if (remaining_dec == '0) begin
          skip_count_next = SKIP_LEN;
          phase_next      = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_count_next = skip_dec;
        if (skip_dec == 2'd0) begin
          size_accumulator_next = '0;
          digit_count_next      = '0;
          phase_next            = PH_SIZE;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_ERR;
      end
    endcase
  end

  // Result word for this byte.
  always_comb begin
    res.payload_valid = valid;
    res.payload_byte  = valid ? data_byte : 8'd0;
    res.message_end   = (phase_next == PH_DONE);
    res.format_error  = (phase_next == PH_ERR);
  end

  // Decoder state advances once per byte that moves to the result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SIZE;
      size_accumulator <= '0;
      digit_count      <= '0;
      bytes_remaining  <= '0;
      skip_count       <= '0;
    end else if (step) begin
      phase            <= phase_next;
      size_accumulator <= size_accumulator_next;
      digit_count      <= digit_count_next;
      bytes_remaining  <= bytes_remaining_next;
      skip_count       <= skip_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cbd_out_reg.sv
`default_nettype none

module cbd_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire cbd_pkg::result_t res,
  output logic                  advance,
  cbd_result_if.source          result
);
  import cbd_pkg::*;

  logic    out_valid;
  result_t out_word;

  // The register takes a new word when it is empty or being drained.
  assign advance = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      out_word <= res;
    end
  end

  assign result.valid         = out_valid;
  assign result.payload_valid = out_word.payload_valid;
  assign result.payload_byte  = out_word.payload_byte;
  assign result.message_end   = out_word.message_end;
  assign result.format_error  = out_word.format_error;

endmodule

`default_nettype wire
